// ===== rtl/pfc_pkg.sv =====
`default_nettype none
package pfc_pkg;

  localparam int VALUE_BITS = 21;
  localparam int COUNT_W    = 5;
  localparam int D_W        = (VALUE_BITS + 1) / 2 + 2;
  localparam int SQ_W       = VALUE_BITS + 2;
  localparam int STEP_W     = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [D_W-1:0]        divisor_t;
  typedef logic [SQ_W-1:0]       square_t;

  localparam count_t COUNT_MAX = '1;

  function automatic count_t count_inc(input count_t c);
    count_inc = (c == COUNT_MAX) ? c : c + count_t'(1);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/prime_factor_count_unit.sv =====
// Time from accept to result valid grows with the trailing zero bits and the
// trial divisions; 0, 1 and powers of two need no trial division. The bit-serial
// remainder unit sets the worst case. A result still held by out_stall delays
// the next one.
// Throughput: one word at a time; the next word is taken once the result is
// in the output register, which may still wait on out_stall.
// Reset: synchronous, active high; clears the sequencer and the output valid.
`default_nettype none
module prime_factor_count_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [pfc_pkg::VALUE_BITS-1:0] value,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [pfc_pkg::COUNT_W-1:0]    factor_count
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVEN  = 5'b00010,
    S_CHECK = 5'b00100,
    S_DIV   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t                   state;
  pfc_pkg::value_t          x;
  pfc_pkg::value_t          quo;
  pfc_pkg::divisor_t        d;
  pfc_pkg::divisor_t        rem;
  pfc_pkg::square_t         sq;
  pfc_pkg::count_t          cnt;
  logic [pfc_pkg::STEP_W-1:0] step;

  logic [pfc_pkg::D_W:0]    rem_sh;
  logic                     ge;
  pfc_pkg::divisor_t        rem_new;
  pfc_pkg::value_t          quo_new;
  pfc_pkg::square_t         sq_step;
  logic                     out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // one restoring division step per cycle
  always_comb begin
    rem_sh  = {rem, quo[pfc_pkg::VALUE_BITS-1]};
    ge      = (rem_sh >= {1'b0, d});
    rem_new = ge ? pfc_pkg::D_W'(rem_sh - {1'b0, d}) : rem_sh[pfc_pkg::D_W-1:0];
    quo_new = {quo[pfc_pkg::VALUE_BITS-2:0], ge};
    sq_step = sq + pfc_pkg::SQ_W'({d, 2'b00}) + pfc_pkg::SQ_W'(4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_free) out_valid <= (state == S_FIN);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x     <= value;
            cnt   <= '0;
            d     <= pfc_pkg::D_W'(3);
            sq    <= pfc_pkg::SQ_W'(9);
            state <= S_EVEN;
          end
        end
        S_EVEN: begin
          if (x < pfc_pkg::VALUE_BITS'(2)) begin
            state <= S_FIN;
          end else if (!x[0]) begin
            cnt <= pfc_pkg::count_inc(cnt);
            x   <= x >> 1;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sq <= pfc_pkg::SQ_W'(x)) begin
            rem   <= '0;
            quo   <= x;
            step  <= '0;
            state <= S_DIV;
          end else begin
            if (x > pfc_pkg::VALUE_BITS'(1)) cnt <= pfc_pkg::count_inc(cnt);
            state <= S_FIN;
          end
        end
        S_DIV: begin
          rem  <= rem_new;
          quo  <= quo_new;
          step <= step + 1'b1;
          if (step == pfc_pkg::STEP_W'(pfc_pkg::VALUE_BITS - 1)) begin
            if (rem_new == '0) begin
              x   <= quo_new;
              cnt <= pfc_pkg::count_inc(cnt);
            end else begin
              d  <= d + pfc_pkg::D_W'(2);
              sq <= sq_step;
            end
            state <= S_CHECK;
          end
        end
        S_FIN: begin
          if (out_free) begin
            factor_count <= cnt;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pfc_checker.sv =====
`default_nettype none
module pfc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic [pfc_pkg::VALUE_BITS-1:0] value,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [pfc_pkg::COUNT_W-1:0]    factor_count
);

  a_reset_clean: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("word accepted while unit free afterwards");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(factor_count))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> factor_count <= pfc_pkg::COUNT_W'(pfc_pkg::VALUE_BITS))
    else $error("count out of range");

endmodule

bind prime_factor_count_unit pfc_checker u_pfc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .value(value),
  .out_valid(out_valid), .out_stall(out_stall), .factor_count(factor_count)
);
`default_nettype wire
